### sv/quadratic_root_solver_unit_defines.svh
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define QRS_ASSERT_COMB(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Payload types, root kind codes and default sizes shared by the solver and its testbench.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CoefW       = 16;
  localparam int OutW        = 48;
  localparam int FracBitsDef = 16;

  // Classification of one result.
  typedef enum logic [1:0] {
    KIND_SINGLE  = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_BAD_A   = 2'd3
  } root_kind_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } in_t;

  typedef struct packed {
    root_kind_e             root_kind;
    logic signed [OutW-1:0] first_value;
    logic signed [OutW-1:0] second_value;
  } out_t;

endpackage

### sv/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit step: takes two radicand bits and resolves one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int XW  = 66,
  parameter int SW  = 33,
  parameter int SDW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [XW-1:0]  x_i,
  input  logic [SW-1:0]  q_i,
  input  logic [SW+1:0]  rem_i,
  input  logic [SDW-1:0] side_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [XW-1:0]  x_o,
  output logic [SW-1:0]  q_o,
  output logic [SW+1:0]  rem_o,
  output logic [SDW-1:0] side_o
);

  logic           valid_q;
  logic [XW-1:0]  x_q;
  logic [SW-1:0]  q_q;
  logic [SW+1:0]  rem_q;
  logic [SDW-1:0] side_q;
  logic [SW+3:0]  r2, trial, diff;
  logic           ge;

  // Bring down the next bit pair and try the next root bit.
  always_comb begin
    r2    = {rem_i, x_i[XW-1 -: 2]};
    trial = {2'b00, q_i, 2'b01};
    ge    = (r2 >= trial);
    diff  = r2 - trial;
  end

  assign ready_o = !valid_q || ready_i;

  // The stage holds its content until the neighbor takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= {x_i[XW-3:0], 2'b00};
      q_q    <= {q_i[SW-2:0], ge};
      rem_q  <= ge ? diff[SW+1:0] : r2[SW+1:0];
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign q_o     = q_q;
  assign rem_o   = rem_q;
  assign side_o  = side_q;

endmodule

### sv/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for both quotient lanes against a shared divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int UW   = 34,
  parameter int DENW = 17,
  parameter int SDW  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [DENW-1:0]      den_i,
  input  logic [1:0][UW-1:0]   n_i,
  input  logic [1:0][DENW:0]   rem_i,
  input  logic [SDW-1:0]       side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [DENW-1:0]      den_o,
  output logic [1:0][UW-1:0]   n_o,
  output logic [1:0][DENW:0]   rem_o,
  output logic [SDW-1:0]       side_o
);

  logic                 valid_q;
  logic [DENW-1:0]      den_q;
  logic [1:0][UW-1:0]   n_q;
  logic [1:0][DENW:0]   rem_q;
  logic [SDW-1:0]       side_q;
  logic [1:0][DENW+1:0] r2, diff;
  logic [1:0]           ge;

  // Shift in the next numerator bit and subtract where the divisor fits.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r2[l]   = {rem_i[l], n_i[l][UW-1]};
      ge[l]   = (r2[l] >= {2'b00, den_i});
      diff[l] = r2[l] - {2'b00, den_i};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Quotient bits enter at the bottom as numerator bits leave at the top.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      den_q  <= den_i;
      side_q <= side_i;
      for (int l = 0; l < 2; l++) begin
        n_q[l]   <= {n_i[l][UW-2:0], ge[l]};
        rem_q[l] <= ge[l] ? diff[l][DENW:0] : r2[l][DENW:0];
      end
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign n_o     = n_q;
  assign rem_o   = rem_q;
  assign side_o  = side_q;

endmodule

### sv/quadratic_root_solver_unit.sv
// Pipeline: product and discriminant registers, SW square root cells, the
// numerator register, UW divider cells and the result register, where SW is the
// root width and UW the numerator magnitude width; one cell per root bit and one cell per quotient bit.
// Throughput: one set per cycle unless stalled; every stage advances on its own.
// Reset clears all stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// Quadratic root solver
// Discriminant, pipelined square root and two-lane divider chains, saturation.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_unit_defines.svh"

module quadratic_root_solver_unit import qrs_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int W    = CoefW;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * W + 1;
  localparam int RW   = DW + 2 * F;
  localparam int SW   = (RW + 1) / 2;
  localparam int XW   = 2 * SW;
  localparam int NBW  = W + F + 1;
  localparam int NUMW = ((NBW > SW + 1) ? NBW : SW + 1) + 1;
  localparam int UW   = NUMW - 1;
  localparam int DENW = W + 1;
  localparam int SQSW = 2 + NBW + 1 + DENW;
  localparam int DVSW = 4;
  localparam int QW   = UW + 1;
  localparam int CW   = ((QW > OutW) ? QW : OutW) + 1;
  localparam logic signed [CW-1:0] SatHi = CW'($signed({1'b0, {(OutW-1){1'b1}}}));
  localparam logic signed [CW-1:0] SatLo = -SatHi - CW'(1);

  // Stage 0: products.
  logic                    v0_q, rdy0;
  logic signed [W-1:0]     a0_q, b0_q;
  logic signed [2*W-1:0]   bb0_q, ac0_q;

  // Stage 1: discriminant and classification.
  logic                    v1_q, rdy1;
  root_kind_e              kind1_q;
  logic [DW-1:0]           mag1_q;
  logic signed [NBW-1:0]   nb1_q;
  logic                    aneg1_q;
  logic [DENW-1:0]         den1_q;

  // Stage 2: numerators.
  logic                    v2_q, rdy2;
  logic [DVSW-1:0]         side2_q;
  logic [DENW-1:0]         den2_q;
  logic [1:0][UW-1:0]      n2_q;

  // Stage 3: result register.
  logic                    v3_q, rdy3;
  out_t                    out_q;

  // Square root chain links.
  logic [SW:0]            sq_v, sq_rdy;
  logic [SW:0][XW-1:0]    sq_x;
  logic [SW:0][SW-1:0]    sq_q;
  logic [SW:0][SW+1:0]    sq_rem;
  logic [SW:0][SQSW-1:0]  sq_side;

  // Divider chain links.
  logic [UW:0]                 dv_v, dv_rdy;
  logic [UW:0][DENW-1:0]       dv_den;
  logic [UW:0][1:0][UW-1:0]    dv_n;
  logic [UW:0][1:0][DENW:0]    dv_rem;
  logic [UW:0][DVSW-1:0]       dv_side;

  assign rdy3       = !v3_q || !out_stall_i;
  assign in_stall_o = !rdy0;

  // Products of the incoming coefficients.
  assign rdy0 = !v0_q || rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      a0_q  <= in_data_i.coef_a;
      b0_q  <= in_data_i.coef_b;
      bb0_q <= in_data_i.coef_b * in_data_i.coef_b;
      ac0_q <= in_data_i.coef_a * in_data_i.coef_c;
    end
  end

  // Magnitude and sign of b*b - 4ac.
  logic [2*W-1:0] uac;
  logic [2*W+1:0] four_ac, bbx, mag_full;
  logic           dneg;
  root_kind_e     kind_d;

  always_comb begin
    uac     = ac0_q[2*W-1] ? (2*W)'(-ac0_q) : (2*W)'(ac0_q);
    four_ac = {uac, 2'b00};
    bbx     = {2'b00, bb0_q};
    dneg    = 1'b0;
    if (ac0_q[2*W-1] || (ac0_q == '0)) begin
      mag_full = bbx + four_ac;
    end else if (bbx >= four_ac) begin
      mag_full = bbx - four_ac;
    end else begin
      mag_full = four_ac - bbx;
      dneg     = 1'b1;
    end
    if (a0_q == '0) begin
      kind_d = KIND_BAD_A;
    end else if (mag_full == '0) begin
      kind_d = KIND_SINGLE;
    end else if (dneg) begin
      kind_d = KIND_COMPLEX;
    end else begin
      kind_d = KIND_TWO;
    end
  end

  assign rdy1 = !v1_q || sq_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      kind1_q <= kind_d;
      mag1_q  <= mag_full[DW-1:0];
      nb1_q   <= -(NBW'(b0_q) <<< F);
      aneg1_q <= a0_q[W-1];
      den1_q  <= a0_q[W-1] ? DENW'(-(DENW'(a0_q) <<< 1)) : DENW'(DENW'(a0_q) <<< 1);
    end
  end

  // Square root chain, one root bit per cell.
  assign sq_v[0]    = v1_q;
  assign sq_x[0]    = XW'(mag1_q) << (2 * F);
  assign sq_q[0]    = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = {kind1_q, nb1_q, aneg1_q, den1_q};
  assign sq_rdy[SW] = rdy2;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .XW  (XW),
      .SW  (SW),
      .SDW (SQSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .ready_o (sq_rdy[i]),
      .x_i     (sq_x[i]),
      .q_i     (sq_q[i]),
      .rem_i   (sq_rem[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_v[i+1]),
      .ready_i (sq_rdy[i+1]),
      .x_o     (sq_x[i+1]),
      .q_o     (sq_q[i+1]),
      .rem_o   (sq_rem[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // Numerators and quotient signs from the root.
  logic [1:0]                 kind_s;
  logic signed [NBW-1:0]      nb_s;
  logic                       aneg_s;
  logic [DENW-1:0]            den_s;
  logic signed [NUMW-1:0]     nbx, sx, num1, num2;
  logic [NUMW-1:0]            mag1, mag2;

  always_comb begin
    {kind_s, nb_s, aneg_s, den_s} = sq_side[SW];
    nbx = NUMW'(nb_s);
    sx  = $signed(NUMW'(sq_q[SW]));
    if (root_kind_e'(kind_s) == KIND_COMPLEX) begin
      num1 = nbx;
      num2 = sx;
    end else begin
      num1 = nbx + sx;
      num2 = nbx - sx;
    end
    mag1 = num1[NUMW-1] ? NUMW'(-num1) : NUMW'(num1);
    mag2 = num2[NUMW-1] ? NUMW'(-num2) : NUMW'(num2);
  end

  assign rdy2 = !v2_q || dv_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= sq_v[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && sq_v[SW]) begin
      side2_q <= {kind_s, num1[NUMW-1] ^ aneg_s, num2[NUMW-1] ^ aneg_s};
      den2_q  <= den_s;
      n2_q[0] <= mag1[UW-1:0];
      n2_q[1] <= mag2[UW-1:0];
    end
  end

  // Divider chain, one quotient bit per cell for both lanes.
  assign dv_v[0]    = v2_q;
  assign dv_den[0]  = den2_q;
  assign dv_n[0]    = n2_q;
  assign dv_rem[0]  = '0;
  assign dv_side[0] = side2_q;
  assign dv_rdy[UW] = rdy3;

  for (genvar j = 0; j < UW; j++) begin : g_div
    qrs_div_cell #(
      .UW   (UW),
      .DENW (DENW),
      .SDW  (DVSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .ready_o (dv_rdy[j]),
      .den_i   (dv_den[j]),
      .n_i     (dv_n[j]),
      .rem_i   (dv_rem[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_v[j+1]),
      .ready_i (dv_rdy[j+1]),
      .den_o   (dv_den[j+1]),
      .n_o     (dv_n[j+1]),
      .rem_o   (dv_rem[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // Apply the sign and clamp into the output range.
  function automatic logic signed [OutW-1:0] sat_value(input logic [UW-1:0] mag,
                                                        input logic neg);
    logic signed [CW-1:0] ext;
    ext = $signed(CW'(mag));
    if (neg) begin
      ext = -ext;
    end
    if (ext > SatHi) begin
      ext = SatHi;
    end else if (ext < SatLo) begin
      ext = SatLo;
    end
    return ext[OutW-1:0];
  endfunction

  out_t        res_d;
  root_kind_e  kind_f;

  always_comb begin
    kind_f              = root_kind_e'(dv_side[UW][3:2]);
    res_d.root_kind     = kind_f;
    res_d.first_value   = sat_value(dv_n[UW][0], dv_side[UW][1]);
    res_d.second_value  = sat_value(dv_n[UW][1], dv_side[UW][0]);
    if (kind_f == KIND_BAD_A) begin
      res_d.first_value  = '0;
      res_d.second_value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= dv_v[UW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && dv_v[UW]) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  // Checks on result consistency.
  `QRS_ASSERT_IMPL(a_bad_a_zero, v3_q && (out_q.root_kind == KIND_BAD_A), (out_q.first_value == '0) && (out_q.second_value == '0), "zero coefficient a must give zero values")
  `QRS_ASSERT_IMPL(a_single_same, v3_q && (out_q.root_kind == KIND_SINGLE), out_q.first_value == out_q.second_value, "double root values differ")
  `QRS_ASSERT_COMB(a_stall_busy, !in_stall_o || (v0_q && v1_q), "input stalled with free front stages")

endmodule

### verif/tb_quadratic_root_solver_unit.sv
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient sets through the valid/stall input channel with random
// gaps, stalls the result channel at random, and checks every result in order
// against its typed row or a fixed-point root predictor. The run starts with
// a directed table and continues with random and constructed double-root sets.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_unit;
  import qrs_pkg::*;

  localparam int FracW      = FracBitsDef;
  localparam int RandomSets = 1140;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 100;

  // One row of the directed table.
  typedef struct {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    bit                      typed;
    root_kind_e              kind;
    longint                  first;
    longint                  second;
  } coef_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  out_t   pending_roots[$];
  int     mismatch_cnt = 0;
  int     cycle_cnt = 0;
  bit     quiet_mode;
  int     stall_left = 0;

  quadratic_root_solver_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Floored square root of a 128-bit value, one digit pair at a time.
  function automatic logic [127:0] floor_sqrt(logic [127:0] x);
    logic [127:0] res;
    logic [127:0] bt;
    res = '0;
    bt  = 128'd1 << 126;
    while (bt != 0 && bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Clamp a quotient into the signed output range.
  function automatic logic signed [OutW-1:0] clamp_out(longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (OutW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OutW-1:0];
  endfunction

  // Expected roots of one coefficient set.
  function automatic out_t predict_roots(in_t d);
    out_t   r;
    longint a;
    longint b;
    longint c;
    longint disc;
    longint nb;
    longint den;
    longint s;
    logic [127:0] mag;
    a = longint'(d.coef_a);
    b = longint'(d.coef_b);
    c = longint'(d.coef_c);
    if (a == 0) begin
      r.root_kind    = KIND_BAD_A;
      r.first_value  = '0;
      r.second_value = '0;
      return r;
    end
    disc = b * b - 4 * a * c;
    den  = 2 * a;
    nb   = -b * (64'sd1 <<< FracW);
    if (disc == 0) begin
      r.root_kind    = KIND_SINGLE;
      r.first_value  = clamp_out(nb / den);
      r.second_value = clamp_out(nb / den);
      return r;
    end
    mag = 128'(disc < 0 ? -disc : disc) << (2 * FracW);
    s   = longint'(floor_sqrt(mag));
    if (disc > 0) begin
      r.root_kind    = KIND_TWO;
      r.first_value  = clamp_out((nb + s) / den);
      r.second_value = clamp_out((nb - s) / den);
    end else begin
      r.root_kind    = KIND_COMPLEX;
      r.first_value  = clamp_out(nb / den);
      r.second_value = clamp_out(s / den);
    end
    return r;
  endfunction

  // Idle length: mostly short, a few long, none in quiet stretches.
  function automatic int idle_len();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one set and hold it until the transfer happens.
  task automatic send_coefs(in_t d, bit typed, out_t known);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    pending_roots.push_back(typed ? known : predict_roots(d));
  endtask

  // Random output stall, in bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
      stall_left  <= idle_len();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result check on every output transfer.
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_r = pending_roots.pop_front();
        if (out_data_o.root_kind !== exp_r.root_kind ||
            out_data_o.first_value !== exp_r.first_value ||
            out_data_o.second_value !== exp_r.second_value) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: expected kind %0d %0d %0d, got kind %0d %0d %0d",
                     exp_r.root_kind, exp_r.first_value, exp_r.second_value,
                     out_data_o.root_kind, out_data_o.first_value,
                     out_data_o.second_value);
        end
      end
    end
  end

  // Timeout.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    coef_row_t rows[$];
    coef_row_t row;
    in_t       d;
    out_t      known;
    int        sel;
    longint    ra;
    longint    rr;
    quiet_mode   = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;

    // Directed cases; typed rows carry results read straight off the formula.
    rows = '{
      '{16'sd0,      16'sd32767,  -16'sd32768, 1'b1, KIND_BAD_A,   0,      0},
      '{16'sd0,      -16'sd32768, 16'sd32767,  1'b1, KIND_BAD_A,   0,      0},
      '{16'sd1,      16'sd0,      16'sd0,      1'b1, KIND_SINGLE,  0,      0},
      '{16'sd1,      -16'sd2,     16'sd1,      1'b1, KIND_SINGLE,  65536,  65536},
      '{16'sd1,      16'sd0,      -16'sd1,     1'b1, KIND_TWO,     65536,  -65536},
      '{16'sd1,      16'sd0,      16'sd1,      1'b1, KIND_COMPLEX, 0,      65536},
      '{-16'sd1,     16'sd0,      16'sd1,      1'b0, KIND_TWO,     0,      0},
      '{-16'sd1,     16'sd0,      -16'sd1,     1'b0, KIND_COMPLEX, 0,      0},
      '{-16'sd32768, -16'sd32768, 16'sd32767,  1'b0, KIND_TWO,     0,      0},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, KIND_TWO,     0,      0},
      '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, KIND_TWO,     0,      0},
      '{16'sd32767,  -16'sd32768, -16'sd32768, 1'b0, KIND_TWO,     0,      0},
      '{-16'sd32768, 16'sd32767,  16'sd32767,  1'b0, KIND_TWO,     0,      0},
      '{16'sd1,      -16'sd32768, 16'sd32767,  1'b0, KIND_TWO,     0,      0},
      '{-16'sd1,     16'sd32767,  -16'sd32768, 1'b0, KIND_TWO,     0,      0},
      '{16'sd3,      16'sd7,      -16'sd5,     1'b0, KIND_TWO,     0,      0},
      '{-16'sd4,     16'sd12,     -16'sd9,     1'b0, KIND_TWO,     0,      0},
      '{16'sd7,      -16'sd3,     16'sd11,     1'b0, KIND_TWO,     0,      0}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      row                = rows[i];
      d.coef_a           = row.a;
      d.coef_b           = row.b;
      d.coef_c           = row.c;
      known.root_kind    = row.kind;
      known.first_value  = row.first;
      known.second_value = row.second;
      send_coefs(d, row.typed, known);
    end

    // Random sets: full range, small values, zero a and constructed double roots.
    for (int n = 0; n < RandomSets; n++) begin
      if (n % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        d = in_t'({$urandom, $urandom});
      end else if (sel < 70) begin
        d.coef_a = $signed(16'($urandom_range(0, 32))) - 16'sd16;
        d.coef_b = $signed(16'($urandom_range(0, 64))) - 16'sd32;
        d.coef_c = $signed(16'($urandom_range(0, 64))) - 16'sd32;
      end else if (sel < 80) begin
        d          = in_t'({$urandom, $urandom});
        d.coef_a   = '0;
      end else begin
        // b*b == 4*a*c with a double root at -b/(2a).
        ra = longint'($urandom_range(1, 40)) * ($urandom_range(0, 1) ? 1 : -1);
        rr = longint'($urandom_range(0, 25)) - 12;
        d.coef_a = ra[CoefW-1:0];
        d.coef_b = 16'(-2 * ra * rr);
        d.coef_c = 16'(ra * rr * rr);
      end
      send_coefs(d, 1'b0, known);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    quiet_mode = 1'b0;

    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
